### rtl/tcrp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcrp_pkg;

  localparam int SLOT_W = 3;
  localparam int KEY_W  = 64;
  localparam int TIME_W = 32;

  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic              mode;
    logic [KEY_W-1:0]  name_key;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] ttl;
  } in_word_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } out_word_t;

  // One cache slot as it is kept in the slot memory.
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] added;
    logic [TIME_W-1:0] expiry;
  } slot_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control from the sequencer to the candidate tracker.
  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctl_t;

endpackage

`default_nettype wire

### rtl/tcrp_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module tcrp_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/tcrp_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module tcrp_scan #(
  parameter int ENTRIES = 8
) (
  input  wire logic                                       clk,
  input  wire tcrp_pkg::scan_ctl_t                        ctl,
  input  wire logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_idx,
  input  wire logic                                       rd_valid,
  input  wire tcrp_pkg::slot_entry_t                      rd_entry,
  input  wire logic [tcrp_pkg::KEY_W-1:0]                 key,
  input  wire logic [tcrp_pkg::TIME_W-1:0]                now,
  output logic                                            found,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0]  hit_idx,
  output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0]  pick_idx,
  output logic                                            pick_evicted,
  output logic [tcrp_pkg::KEY_W-1:0]                      pick_key
);

  import tcrp_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Running candidates, one per priority class. Each sampled slot updates
  // them in ascending slot order, so "first found" is kept by the flags.
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic              exp_r;
  logic [IDX_W-1:0]  exp_idx_r;
  logic [KEY_W-1:0]  exp_key_r;
  logic              emp_r;
  logic [IDX_W-1:0]  emp_idx_r;
  logic              old_r;
  logic [IDX_W-1:0]  old_idx_r;
  logic [TIME_W-1:0] old_added_r;
  logic [KEY_W-1:0]  old_key_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hit_r <= 1'b0;
      exp_r <= 1'b0;
      emp_r <= 1'b0;
      old_r <= 1'b0;
    end else if (ctl.sample) begin
      if (rd_valid && (rd_entry.key == key) && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx;
      end
      if (rd_valid && (rd_entry.expiry < now) && !exp_r) begin
        exp_r     <= 1'b1;
        exp_idx_r <= rd_idx;
        exp_key_r <= rd_entry.key;
      end
      if (!rd_valid && !emp_r) begin
        emp_r     <= 1'b1;
        emp_idx_r <= rd_idx;
      end
      // Only consulted when every slot is valid; strict compare keeps the
      // lowest slot among equal ages.
      if (!old_r || (rd_entry.added < old_added_r)) begin
        old_r       <= 1'b1;
        old_idx_r   <= rd_idx;
        old_added_r <= rd_entry.added;
        old_key_r   <= rd_entry.key;
      end
    end
  end

  always_comb begin
    found   = hit_r;
    hit_idx = hit_idx_r;
    if (hit_r) begin
      pick_idx     = hit_idx_r;
      pick_evicted = 1'b1;
      pick_key     = key;
    end else if (exp_r) begin
      pick_idx     = exp_idx_r;
      pick_evicted = 1'b1;
      pick_key     = exp_key_r;
    end else if (emp_r) begin
      pick_idx     = emp_idx_r;
      pick_evicted = 1'b0;
      pick_key     = '0;
    end else begin
      pick_idx     = old_idx_r;
      pick_evicted = 1'b1;
      pick_key     = old_key_r;
    end
  end

endmodule

`default_nettype wire

### rtl/ttl_cache_replacement_policy.sv
`timescale 1ns / 1ps
`default_nettype none

// TTL cache with FIFO-style eviction over ENTRIES fully associative slots.
// Usage: drive in_word and raise start; the word is taken at the rising edge
// where start is high and busy is low. in_word.mode selects a lookup, which
// only reports the first valid slot holding the key, or an insert, which
// writes the key into the same-key slot, else the first expired slot, else
// the first empty slot, else the oldest slot, and reports what it evicted.
// The result word appears on out_word for exactly one cycle with out_valid
// high. The receiver cannot stall; it must take the word in that cycle.
// Sequence: the slot memory is read one slot per cycle through its single
// read port, a drain state then samples the last read, and a decision
// state writes the chosen slot on an insert; the result strobe is registered
// after the decision state. A new word can be accepted in the same cycle the
// result is shown, but not before the previous operation has finished.
// Keys and times live in a synchronous RAM; the per-slot valid bits are
// flip-flops, so reset empties the cache at once and no clearing pass is
// needed. Reset is synchronous and active low.
module ttl_cache_replacement_policy #(
  parameter int ENTRIES = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire tcrp_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output tcrp_pkg::out_word_t      out_word
);

  import tcrp_pkg::*;

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ENTRY_W = $bits(slot_entry_t);

  // Sequencer state and the latched request.
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r;
  logic               rd_pend_r;
  logic [IDX_W-1:0]   rd_idx_r;
  in_word_t           req_r;
  logic [ENTRIES-1:0] valid_r;
  logic               out_valid_r;
  out_word_t          out_word_r, out_word_nxt;

  logic               accept;
  logic               ram_re;
  logic               ram_we;
  slot_entry_t        ram_wdata;
  slot_entry_t        ram_rdata;
  scan_ctl_t          scan_ctl;

  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   pick_idx;
  logic               pick_evicted;
  logic [KEY_W-1:0]   pick_key;

  logic [TIME_W:0]    expiry_sum;
  logic [TIME_W-1:0]  expiry;

  tcrp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pick_idx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cnt_r),
    .rdata (ram_rdata)
  );

  tcrp_scan #(
    .ENTRIES (ENTRIES)
  ) u_scan (
    .clk          (clk),
    .ctl          (scan_ctl),
    .rd_idx       (rd_idx_r),
    .rd_valid     (valid_r[rd_idx_r]),
    .rd_entry     (ram_rdata),
    .key          (req_r.name_key),
    .now          (req_r.now),
    .found        (found),
    .hit_idx      (hit_idx),
    .pick_idx     (pick_idx),
    .pick_evicted (pick_evicted),
    .pick_key     (pick_key)
  );

  // Next-state logic: scan every slot, wait for the last read, then decide.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Output decode of the sequencer.
  always_comb begin
    busy            = 1'b1;
    accept          = 1'b0;
    ram_re          = 1'b0;
    ram_we          = 1'b0;
    scan_ctl.clear  = 1'b0;
    scan_ctl.sample = rd_pend_r;
    unique case (state_r)
      ST_IDLE: begin
        busy           = 1'b0;
        accept         = start;
        scan_ctl.clear = start;
      end
      ST_SCAN:   ram_re = 1'b1;
      ST_DRAIN:  ram_re = 1'b0;
      ST_FINISH: ram_we = (req_r.mode == MODE_INSERT);
      default:   busy   = 1'b1;
    endcase
  end

  // Expiry saturates at the largest representable time.
  always_comb begin
    expiry_sum = {1'b0, req_r.now} + {1'b0, req_r.ttl};
    expiry     = expiry_sum[TIME_W] ? TIME_MAX : expiry_sum[TIME_W-1:0];
    ram_wdata.key    = req_r.name_key;
    ram_wdata.added  = req_r.now;
    ram_wdata.expiry = expiry;
  end

  // Result word. A lookup never evicts; a miss reports slot zero.
  always_comb begin
    out_word_nxt.found = found;
    if (req_r.mode == MODE_INSERT) begin
      out_word_nxt.slot        = SLOT_W'(pick_idx);
      out_word_nxt.evicted     = pick_evicted;
      out_word_nxt.evicted_key = pick_key;
    end else begin
      out_word_nxt.slot        = found ? SLOT_W'(hit_idx) : '0;
      out_word_nxt.evicted     = 1'b0;
      out_word_nxt.evicted_key = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_pend_r   <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= ram_re;
      out_valid_r <= (state_r == ST_FINISH);
      if (ram_we) begin
        valid_r[pick_idx] <= 1'b1;
      end
    end
  end

  // Payload and address registers need no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_word;
      cnt_r <= '0;
    end else if (ram_re && (cnt_r != IDX_W'(ENTRIES - 1))) begin
      cnt_r <= cnt_r + 1'b1;
    end
    rd_idx_r <= cnt_r;
    if (state_r == ST_FINISH) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // A result strobe follows exactly one decision cycle.
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ST_FINISH))
    else $error("result strobe without a preceding decision cycle");

  // The slot memory is only written by an insert at its decision cycle.
  a_write_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_FINISH) && (req_r.mode == MODE_INSERT))
    else $error("slot memory written outside an insert decision");

  // An accepted word makes the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A read never lands while the memory is being written.
  a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re && !rd_pend_r)
    else $error("slot memory read overlaps a write");
`endif

endmodule

`default_nettype wire
